// ----- design/olist_pkg.sv -----
`default_nettype none

package olist_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the request and result
    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int PLACE_W  = 8;
    localparam int STAT_W   = 2;
    localparam int OUT_W    = 5;

    // Width that holds both a place and a count plus one
    localparam int CMPW     = ((PLACE_W > CNT_W) ? PLACE_W : CNT_W) + 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_AT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOKEY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic
    {
        S_IDLE,
        S_APPLY
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic capture;  // latch the request and the key match vector
        logic apply;    // update the list and load the result registers
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- design/olist_ctrl.sv -----
`default_nettype none

module olist_ctrl
    import olist_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      dp_cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall       = 1'b1;
        dp_cmd.capture = 1'b0;
        dp_cmd.apply   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall       = 1'b0;
                dp_cmd.capture = in_valid;
            end
            S_APPLY:
            begin
                dp_cmd.apply = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/olist_dpath.sv -----
`default_nettype none

module olist_dpath
    import olist_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dp_cmd_t                   dp_cmd,
    input  wire logic        [CMD_W-1:0]   command,
    input  wire logic signed [VAL_W-1:0]   value,
    input  wire logic        [PLACE_W-1:0] place,
    output logic             [STAT_W-1:0]  status,
    output logic             [OUT_W-1:0]   found_place,
    output logic             [OUT_W-1:0]   entry_count
);

    logic [VAL_W-1:0]   entries_reg [CAPACITY];
    logic [VAL_W-1:0]   entries_next [CAPACITY];
    logic [CNT_W-1:0]   used_count_reg;
    logic [CNT_W-1:0]   used_count_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [PLACE_W-1:0] place_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;

    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic [OUT_W-1:0]   found_reg;
    logic [OUT_W-1:0]   found_next;
    logic [OUT_W-1:0]   count_reg;

    logic               hit;
    logic [IDX_W-1:0]   first_idx;
    logic               full;
    logic               bad_place;
    logic [IDX_W-1:0]   ins_pos;
    logic               do_ins;
    logic               do_del;

    // Compare the key against every live cell at capture
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (entries_reg[i] == value) &&
                            (CNT_W'(i) < used_count_reg);
        end
    end

    // Lowest matching cell
    always_comb
    begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign hit       = |match_reg;
    assign full      = (used_count_reg == CNT_W'(CAPACITY));
    assign bad_place = (place_reg == '0) ||
                       (CMPW'(place_reg) > (CMPW'(used_count_reg) + CMPW'(1)));

    // Decide the operation
    always_comb
    begin
        status_next     = ST_OK;
        found_next      = '0;
        do_ins          = 1'b0;
        do_del          = 1'b0;
        ins_pos         = '0;
        used_count_next = used_count_reg;
        case (cmd_reg)
            CMD_FRONT, CMD_APPEND, CMD_AT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (cmd_reg == CMD_FRONT)
                begin
                    do_ins = 1'b1;
                end
                else if (cmd_reg == CMD_APPEND)
                begin
                    do_ins  = 1'b1;
                    ins_pos = IDX_W'(used_count_reg);
                end
                else if (bad_place)
                begin
                    status_next = ST_NOPOS;
                end
                else
                begin
                    do_ins  = 1'b1;
                    ins_pos = IDX_W'(place_reg - PLACE_W'(1));
                end
                if (do_ins)
                begin
                    used_count_next = used_count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (!hit)
                begin
                    status_next = ST_NOKEY;
                end
                else
                begin
                    do_del          = 1'b1;
                    used_count_next = used_count_reg - CNT_W'(1);
                end
            end
            CMD_SEARCH:
            begin
                if (!hit)
                begin
                    status_next = ST_NOKEY;
                end
                else
                begin
                    found_next = OUT_W'(CNT_W'(first_idx) + CNT_W'(1));
                end
            end
            CMD_CLEAR:
            begin
                used_count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Cell chain: shift up to open a gap, shift down to close one
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        if (do_ins)
        begin
            if (ins_pos == '0)
            begin
                entries_next[0] = value_reg;
            end
            for (int i = 1; i < CAPACITY; i++)
            begin
                if (IDX_W'(i) > ins_pos)
                begin
                    entries_next[i] = entries_reg[i-1];
                end
                else if (IDX_W'(i) == ins_pos)
                begin
                    entries_next[i] = value_reg;
                end
            end
        end
        else if (do_del)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                if (IDX_W'(i) >= first_idx)
                begin
                    entries_next[i] = entries_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg   <= command;
            value_reg <= value;
            place_reg <= place;
            match_reg <= match_next;
        end
        if (dp_cmd.apply)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            status_reg <= status_next;
            found_reg  <= found_next;
            count_reg  <= OUT_W'(used_count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (dp_cmd.apply)
        begin
            used_count_reg <= used_count_next;
        end
    end

    assign status      = status_reg;
    assign found_place = found_reg;
    assign entry_count = count_reg;

endmodule

`default_nettype wire

// ----- design/ordered_list_engine_unit.sv -----
// A request's command, value, place and key match vector are captured when it is accepted;
// its result is loaded into the result registers when the controller applies it, once the output is free.
// The capture/apply controller takes no new request until the last one is applied; a
// stalled result holds the engine in apply until the output register frees up.
// Reset (rst_n, asynchronous, active low) empties the list and drops any pending result;
// list cells are not cleared and are only read after being written.
`default_nettype none

module ordered_list_engine_unit
    import olist_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Request channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [CMD_W-1:0]   command,
    input  wire logic signed [VAL_W-1:0]   value,
    input  wire logic        [PLACE_W-1:0] place,
    // Result channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic             [STAT_W-1:0]  status,
    output logic             [OUT_W-1:0]   found_place,
    output logic             [OUT_W-1:0]   entry_count
);

    dp_cmd_t dp_cmd;

    // Sequence capture and apply; own the result valid flag
    olist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    // Hold the list cells, match vector and result registers
    olist_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .command     (command),
        .value       (value),
        .place       (place),
        .status      (status),
        .found_place (found_place),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench
    import olist_pkg::*;
;

    // Command codes the block leaves unused: they must answer ok and leave the list alone
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result
    localparam int PHASE_ITEMS  = 420;

    // One result as the block should report it
    typedef struct packed
    {
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  found_place;
        logic [OUT_W-1:0]  entry_count;
    } olist_result_t;

    // Shadow copy of the list plus the queue of results still owed by the block
    class list_scoreboard;
        logic signed [VAL_W-1:0] cells [CAPACITY];
        int unsigned             used;
        olist_result_t           awaited [$];
        int                      errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        // Shift the tail up one slot and drop the value into the gap
        function void open_gap(int unsigned pos, logic signed [VAL_W-1:0] val);
            for (int i = used; i > pos; i--)
                cells[i] = cells[i - 1];
            cells[pos] = val;
            used++;
        endfunction

        // First slot holding the key, or -1
        function int locate(logic signed [VAL_W-1:0] key);
            for (int i = 0; i < used; i++)
                if (cells[i] == key)
                    return i;
            return -1;
        endfunction

        // Apply one accepted request to the shadow list and queue its result
        function void note_request(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                                   logic [PLACE_W-1:0] pl);
            olist_result_t r;
            int            slot;
            r.status      = ST_OK;
            r.found_place = '0;
            case (cmd)
                CMD_FRONT, CMD_APPEND, CMD_AT:
                begin
                    // Fullness wins over a bad position
                    if (used >= CAPACITY)
                        r.status = ST_FULL;
                    else if (cmd == CMD_FRONT)
                        open_gap(0, val);
                    else if (cmd == CMD_APPEND)
                        open_gap(used, val);
                    else if (pl == 0 || pl > used + 1)
                        r.status = ST_NOPOS;
                    else
                        open_gap(pl - 1, val);
                end
                CMD_DELETE:
                begin
                    slot = locate(val);
                    if (slot < 0)
                        r.status = ST_NOKEY;
                    else
                    begin
                        for (int i = slot; i + 1 < used; i++)
                            cells[i] = cells[i + 1];
                        used--;
                    end
                end
                CMD_SEARCH:
                begin
                    slot = locate(val);
                    if (slot < 0)
                        r.status = ST_NOKEY;
                    else
                        r.found_place = OUT_W'(slot + 1);
                end
                CMD_CLEAR:
                    used = 0;
                default:
                    ;
            endcase
            r.entry_count = OUT_W'(used);
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Match one result against the oldest outstanding request
        function void check_result(logic [STAT_W-1:0] st, logic [OUT_W-1:0] fp,
                                   logic [OUT_W-1:0] cnt);
            olist_result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: status %0d found_place %0d entry_count %0d",
                       st, fp, cnt);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, st);
            compare_field("found_place", want.found_place, fp);
            compare_field("entry_count", want.entry_count, cnt);
        endfunction
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic        [CMD_W-1:0]   command     = CMD_CLEAR;
    logic signed [VAL_W-1:0]   value       = '0;
    logic        [PLACE_W-1:0] place       = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic        [STAT_W-1:0]  status;
    logic        [OUT_W-1:0]   found_place;
    logic        [OUT_W-1:0]   entry_count;

    list_scoreboard sb = new();

    // Idle/stall odds in percent, changed per phase by the main sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Bump hold_token to ask the receiver for one long hold-off
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int quiet      = 0;

    ordered_list_engine_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .place       (place),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_place (found_place),
        .entry_count (entry_count)
    );

    always #2 clk = ~clk;

    // Receiver: check what was taken at this edge, then pick the stall for the next cycle.
    // Values read here are the ones settled before the edge.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result(status, found_place, entry_count);
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            // Hold the output shut so the block backs up into its request side
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request, idling first at the phase's odds; return at the accepting edge
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                                input logic [PLACE_W-1:0] pl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        place    <= pl;
        @(posedge clk);
        // Hold the payload until the block takes it
        while (in_stall)
            @(posedge clk);
        sb.note_request(cmd, val, pl);
    endtask

    // Random requests, mostly aimed at what the list holds so that deletes and
    // searches hit, positions mostly near the valid range, and a little noise
    task automatic random_requests(input int n);
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] val;
        logic [PLACE_W-1:0]      pl;
        int                      pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                cmd = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
            else if (pick < 5)
                cmd = CMD_CLEAR;
            else if (pick < 25)
                cmd = CMD_FRONT;
            else if (pick < 45)
                cmd = CMD_APPEND;
            else if (pick < 65)
                cmd = CMD_AT;
            else if (pick < 82)
                cmd = CMD_DELETE;
            else
                cmd = CMD_SEARCH;

            pick = $urandom_range(9);
            if (sb.used > 0 && pick < 5)
                val = sb.cells[$urandom_range(sb.used - 1)];
            else if (pick < 8)
                val = $signed($urandom_range(15)) - 8;   // small pool: duplicates
            else
                val = $urandom();

            if ($urandom_range(99) < 85)
                pl = PLACE_W'($urandom_range(sb.used + 2));
            else
                pl = PLACE_W'($urandom_range(255));

            send_request(cmd, val, pl);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list misses and bad positions
        send_request(CMD_SEARCH, 0, 0);
        send_request(CMD_DELETE, 0, 0);
        send_request(CMD_AT, 5, 0);
        send_request(CMD_AT, 6, 2);
        // Insert at position 1 of an empty list, then the value extremes at both ends
        send_request(CMD_AT, 7, 1);
        send_request(CMD_FRONT, 32'sh7FFF_FFFF, 0);
        send_request(CMD_APPEND, 32'sh8000_0000, 0);
        // Position count+1 appends; then one in the middle
        send_request(CMD_AT, -1, 4);
        send_request(CMD_AT, 0, 2);
        // Fill up to capacity with a mix of insert kinds
        while (sb.used < CAPACITY)
        begin
            case (sb.used % 3)
                0: send_request(CMD_FRONT, $signed(sb.used), 0);
                1: send_request(CMD_APPEND, -$signed(sb.used), 0);
                default: send_request(CMD_AT, 100, PLACE_W'($urandom_range(1, sb.used + 1)));
            endcase
        end
        // Full list: fullness reported even with a bad position
        send_request(CMD_FRONT, 1, 0);
        send_request(CMD_AT, 1, 0);
        send_request(CMD_AT, 1, 255);
        send_request(CMD_SEARCH, -1, 0);
        send_request(CMD_DELETE, 32'sh8000_0000, 0);
        send_request(CMD_SPARE_LO, 3, 9);
        send_request(CMD_SPARE_HI, 3, 9);
        send_request(CMD_CLEAR, 0, 0);

        // Random phases: no idling, sender idle, receiver stalling, both
        random_requests(PHASE_ITEMS);
        send_idle_pct = 58;
        random_requests(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        random_requests(PHASE_ITEMS);
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        random_requests(PHASE_ITEMS);

        // Pressure: receiver holds off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token++;
        random_requests(70);

        // Drop valid and drain the outstanding results
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/olist_pkg.sv
design/olist_ctrl.sv
design/olist_dpath.sv
design/ordered_list_engine_unit.sv
test/testbench.sv
